FILE: sv/lspq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspq_pkg: shared types and constants of the learned-scale pitch quantizer
// Widths, control/status structs, state encoding and the mod-12 helper.
// ----------------------------------------------------------------------------
package lspq_pkg;

	localparam int SCALE_SLOTS   = 6;
	localparam int SLOT_IDX_W    = (SCALE_SLOTS > 1) ? $clog2(SCALE_SLOTS) : 1;
	localparam int PITCH_CLASSES = 12;
	localparam int CLS_W         = 4;
	localparam int NOTE_W        = 7;
	localparam int SHIFT_W       = 8;
	localparam int MAP_W         = 8;
	localparam int OUT_W         = 8;
	localparam int SUM_W         = 9;
	localparam int TOP_OFFSET    = 108;
	localparam int MAX_SWEEPS    = PITCH_CLASSES + 2;
	localparam int SWEEP_W       = 4;

	localparam logic [CLS_W-1:0] LOW_KEY_RST  = CLS_W'(11);
	localparam logic [CLS_W-1:0] HIGH_KEY_RST = '0;
	localparam logic [CLS_W-1:0] LAST_CLASS   = CLS_W'(PITCH_CLASSES - 1);

	localparam logic MODE_RECORD   = 1'b0;
	localparam logic MODE_QUANTIZE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SWEEP
	} lspq_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture input item
		logic record;  // learn pitch class
		logic init;    // seed map from slots, find key range
		logic step;    // one class of a fill sweep
		logic quant;   // clamp, offset, register result
	} lspq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic mode;
		logic dirty;
		logic sweep_done;
	} lspq_sts_t;

	// n mod 12 for a 7-bit value: quotient by reciprocal 43/512, exact on 0..127
	function automatic logic [CLS_W-1:0] mod12(input logic [NOTE_W-1:0] n);
		logic [12:0]       prod;
		logic [CLS_W-1:0]  q;
		logic [NOTE_W-1:0] q12;
		logic [NOTE_W-1:0] r;
		prod = 13'(n) * 13'd43;
		q    = prod[12:9];
		q12  = NOTE_W'(q) * NOTE_W'(PITCH_CLASSES);
		r    = n - q12;
		return r[CLS_W-1:0];
	endfunction

endpackage

FILE: sv/lspq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspq_ctrl: sequencing controller
// Accepts an item, dispatches record / rebuild / quantize commands.
// ----------------------------------------------------------------------------
module lspq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  lspq_pkg::lspq_sts_t sts,
	output lspq_pkg::lspq_cmd_t cmd,
	output logic                busy
);

	lspq_pkg::lspq_state_t state_q;
	lspq_pkg::lspq_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lspq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		busy     = 1'b1;
		unique case (state_q)
			lspq_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_nx = lspq_pkg::ST_DISPATCH;
				end
			end
			lspq_pkg::ST_DISPATCH: begin
				if (sts.mode == lspq_pkg::MODE_RECORD) begin
					cmd.record = 1'b1;
					state_nx   = lspq_pkg::ST_IDLE;
				end else if (sts.dirty) begin
					cmd.init = 1'b1;
					state_nx = lspq_pkg::ST_SWEEP;
				end else begin
					cmd.quant = 1'b1;
					state_nx  = lspq_pkg::ST_IDLE;
				end
			end
			lspq_pkg::ST_SWEEP: begin
				cmd.step = 1'b1;
				// dirty drops with the last step; dispatch then quantizes
				if (sts.sweep_done) begin
					state_nx = lspq_pkg::ST_DISPATCH;
				end
			end
			default: begin
				state_nx = lspq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/lspq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspq_dp: scale, offset map and quantize datapath
// Slot ring, 12-entry offset map with fill bits, sweep unit, clamp/offset.
// ----------------------------------------------------------------------------
module lspq_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  lspq_pkg::lspq_cmd_t                    cmd,
	output lspq_pkg::lspq_sts_t                    sts,
	input  logic                                   mode,
	input  logic [lspq_pkg::NOTE_W-1:0]            note,
	input  logic signed [lspq_pkg::SHIFT_W-1:0]    shift,
	output logic                                   done,
	output logic [lspq_pkg::OUT_W-1:0]             quantized_note
);

	// captured item
	logic                                  mode_q;
	logic [lspq_pkg::NOTE_W-1:0]           note_q;
	logic signed [lspq_pkg::SHIFT_W-1:0]   shift_q;

	// scale state
	logic [lspq_pkg::CLS_W-1:0]            slots_q [lspq_pkg::SCALE_SLOTS];
	logic [lspq_pkg::SLOT_IDX_W-1:0]       widx_q;
	logic signed [lspq_pkg::MAP_W-1:0]     map_q [lspq_pkg::PITCH_CLASSES];
	logic [lspq_pkg::PITCH_CLASSES-1:0]    filled_q;
	logic [lspq_pkg::CLS_W-1:0]            lowest_q;
	logic [lspq_pkg::CLS_W-1:0]            highest_q;
	logic                                  dirty_q;

	// sweep unit
	logic [lspq_pkg::CLS_W-1:0]            idx_q;
	logic [lspq_pkg::SWEEP_W-1:0]          sweeps_q;
	logic                                  pending_q;

	// result
	logic                                  done_q;
	logic [lspq_pkg::OUT_W-1:0]            result_q;

	// record helpers
	logic [lspq_pkg::CLS_W-1:0]            rec_cls;
	logic                                  rec_hit;

	// init helpers
	logic [lspq_pkg::PITCH_CLASSES-1:0]    seed;
	logic [lspq_pkg::CLS_W-1:0]            seed_lo;
	logic [lspq_pkg::CLS_W-1:0]            seed_hi;

	// sweep helpers
	logic [lspq_pkg::CLS_W-1:0]            left_idx;
	logic [lspq_pkg::CLS_W-1:0]            right_idx;
	logic                                  pend;
	logic [lspq_pkg::SWEEP_W-1:0]          sweeps_nx;
	logic                                  last_step;

	// quantize helpers
	logic signed [lspq_pkg::SUM_W-1:0]     v_raw;
	logic signed [lspq_pkg::SUM_W-1:0]     v_lo;
	logic signed [lspq_pkg::SUM_W-1:0]     v_hi;
	logic [lspq_pkg::NOTE_W-1:0]           v_clamp;
	logic [lspq_pkg::CLS_W-1:0]            q_cls;
	logic [lspq_pkg::CLS_W-1:0]            rd_idx;
	logic signed [lspq_pkg::MAP_W-1:0]     map_rd;

	assign rec_cls = lspq_pkg::mod12(note_q);

	always_comb begin
		rec_hit = 1'b0;
		for (int s = 0; s < lspq_pkg::SCALE_SLOTS; s++) begin
			if (slots_q[s] == rec_cls) begin
				rec_hit = 1'b1;
			end
		end
	end

	always_comb begin
		seed = '0;
		for (int s = 0; s < lspq_pkg::SCALE_SLOTS; s++) begin
			seed[slots_q[s]] = 1'b1;
		end
	end

	always_comb begin
		seed_lo = lspq_pkg::LOW_KEY_RST;
		seed_hi = lspq_pkg::HIGH_KEY_RST;
		for (int c = lspq_pkg::PITCH_CLASSES - 1; c >= 0; c--) begin
			if (seed[c]) begin
				seed_lo = lspq_pkg::CLS_W'(c);
			end
		end
		for (int c = 0; c < lspq_pkg::PITCH_CLASSES; c++) begin
			if (seed[c]) begin
				seed_hi = lspq_pkg::CLS_W'(c);
			end
		end
	end

	assign left_idx  = (idx_q == '0) ? lspq_pkg::LAST_CLASS : idx_q - 1'b1;
	assign right_idx = (idx_q == lspq_pkg::LAST_CLASS) ? '0 : idx_q + 1'b1;
	assign pend      = pending_q | ~filled_q[idx_q];
	assign sweeps_nx = sweeps_q + 1'b1;
	assign last_step = (idx_q == lspq_pkg::LAST_CLASS) &&
		(!pend || (sweeps_nx == lspq_pkg::SWEEP_W'(lspq_pkg::MAX_SWEEPS)));

	// clamp note+shift into [lowest, 108+highest]; lower bound is never negative
	assign v_raw = $signed({2'b00, note_q}) + lspq_pkg::SUM_W'(shift_q);
	assign v_lo  = $signed(lspq_pkg::SUM_W'(lowest_q));
	assign v_hi  = $signed(lspq_pkg::SUM_W'(lspq_pkg::TOP_OFFSET) +
		lspq_pkg::SUM_W'(highest_q));

	always_comb begin
		if (v_raw < v_lo) begin
			v_clamp = lspq_pkg::NOTE_W'(v_lo);
		end else if (v_raw > v_hi) begin
			v_clamp = lspq_pkg::NOTE_W'(v_hi);
		end else begin
			v_clamp = lspq_pkg::NOTE_W'(v_raw);
		end
	end

	assign q_cls  = lspq_pkg::mod12(v_clamp);
	assign rd_idx = cmd.quant ? q_cls : idx_q;
	assign map_rd = map_q[rd_idx];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			note_q  <= note;
			shift_q <= shift;
		end
		if (cmd.quant) begin
			result_q <= lspq_pkg::OUT_W'(lspq_pkg::OUT_W'(v_clamp) + map_rd);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < lspq_pkg::SCALE_SLOTS; s++) begin
				slots_q[s] <= '0;
			end
			for (int c = 0; c < lspq_pkg::PITCH_CLASSES; c++) begin
				map_q[c] <= '0;
			end
			widx_q    <= '0;
			filled_q  <= '0;
			lowest_q  <= lspq_pkg::LOW_KEY_RST;
			highest_q <= lspq_pkg::HIGH_KEY_RST;
			dirty_q   <= 1'b0;
			idx_q     <= '0;
			sweeps_q  <= '0;
			pending_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.quant;

			if (cmd.record && !rec_hit) begin
				slots_q[widx_q] <= rec_cls;
				widx_q <= (widx_q == lspq_pkg::SLOT_IDX_W'(lspq_pkg::SCALE_SLOTS - 1)) ?
					'0 : widx_q + 1'b1;
				dirty_q <= 1'b1;
			end

			if (cmd.init) begin
				filled_q <= seed;
				for (int c = 0; c < lspq_pkg::PITCH_CLASSES; c++) begin
					if (seed[c]) begin
						map_q[c] <= '0;
					end
				end
				lowest_q  <= seed_lo;
				highest_q <= seed_hi;
				idx_q     <= '0;
				sweeps_q  <= '0;
				pending_q <= 1'b0;
			end

			if (cmd.step) begin
				// a held class fills its left neighbor first, else its right one
				if (filled_q[idx_q]) begin
					if (!filled_q[left_idx]) begin
						map_q[left_idx]    <= map_rd + lspq_pkg::MAP_W'(1);
						filled_q[left_idx] <= 1'b1;
					end else if (!filled_q[right_idx]) begin
						map_q[right_idx]    <= map_rd - lspq_pkg::MAP_W'(1);
						filled_q[right_idx] <= 1'b1;
					end
				end
				if (idx_q == lspq_pkg::LAST_CLASS) begin
					idx_q     <= '0;
					sweeps_q  <= sweeps_nx;
					pending_q <= 1'b0;
				end else begin
					idx_q     <= idx_q + 1'b1;
					pending_q <= pend;
				end
				if (last_step) begin
					dirty_q <= 1'b0;
				end
			end
		end
	end

	assign sts.mode       = mode_q;
	assign sts.dirty      = dirty_q;
	assign sts.sweep_done = last_step;

	assign done           = done_q;
	assign quantized_note = result_q;

endmodule

FILE: sv/learned_scale_pitch_quantizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// learned_scale_pitch_quantizer: note quantizer onto a learned scale
// Top level: controller plus datapath, command-style start/busy/done ports.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge where start is high and busy is low.
// mode 0 records the pitch class of note into a six-slot ring (no result);
// mode 1 quantizes note+shift and returns quantized_note with done high for
// exactly one cycle. There is no back-pressure: the receiver must take the
// result in that cycle. A record, or a quantize on an up-to-date map, keeps
// busy high only while in the dispatch state; done is high in the
// first cycle with busy low again, which is also the first cycle a new item
// can be taken. The first quantize after a record that changed the scale
// first rebuilds the offset map with a shared sweep unit that visits one
// pitch class per clock, for up to 14 sweeps, before it quantizes (typical
// scales settle in two or three sweeps).
// ----------------------------------------------------------------------------
module learned_scale_pitch_quantizer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                mode,
	input  logic [lspq_pkg::NOTE_W-1:0]         note,
	input  logic signed [lspq_pkg::SHIFT_W-1:0] shift,
	output logic                                done,
	output logic [lspq_pkg::OUT_W-1:0]          quantized_note
);

	lspq_pkg::lspq_cmd_t cmd;
	lspq_pkg::lspq_sts_t sts;

	// state machine: idle -> dispatch -> (sweep ... -> dispatch) -> idle
	lspq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// slot ring, offset map, sweep unit, clamp and offset add
	lspq_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.mode           (mode),
		.note           (note),
		.shift          (shift),
		.done           (done),
		.quantized_note (quantized_note)
	);

	// a result only follows a busy cycle (the dispatch that quantized)
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without preceding busy cycle");

	// an accepted transfer always makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transfer did not raise busy");

	// sweep steps only run while the map is stale
	a_step_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> sts.dirty)
		else $error("sweep step on a clean map");

	// a record never yields a result
	a_record_silent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.record |=> !done)
		else $error("record produced a result");

endmodule

FILE: tb/lspq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspq_checker: scoreboard for the learned-scale pitch quantizer
// Tracks the learned scale and its offset map, predicts quantized notes and
// compares them in order with the results the block returns.
// ----------------------------------------------------------------------------
module lspq_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic                                mode,
	input  logic [lspq_pkg::NOTE_W-1:0]         note,
	input  logic signed [lspq_pkg::SHIFT_W-1:0] shift,
	input  logic                                done,
	input  logic [lspq_pkg::OUT_W-1:0]          quantized_note,
	output int                                  fault_count,
	output int                                  notes_owed
);
	import lspq_pkg::*;

	localparam int REPORT_MAX = 10;

	logic [CLS_W-1:0] learned_key[SCALE_SLOTS];
	int               ring_ptr;
	int               class_offset[PITCH_CLASSES];
	logic [CLS_W-1:0] low_key;
	logic [CLS_W-1:0] high_key;
	bit               offsets_stale;

	logic [OUT_W-1:0] pitch_expect[$];
	int               faults = 0;

	function automatic void clear_scale();
		int i;
		for (i = 0; i < SCALE_SLOTS; i++)
			learned_key[i] = '0;
		for (i = 0; i < PITCH_CLASSES; i++)
			class_offset[i] = 0;
		ring_ptr      = 0;
		low_key       = LOW_KEY_RST;
		high_key      = HIGH_KEY_RST;
		offsets_stale = 1'b0;
	endfunction

	// learn a pitch class; a class already held is a no-op
	function automatic void learn_class(logic [NOTE_W-1:0] n);
		logic [CLS_W-1:0] pc;
		int i;
		pc = CLS_W'(int'(n) % PITCH_CLASSES);
		for (i = 0; i < SCALE_SLOTS; i++)
			if (learned_key[i] == pc)
				return;
		if (ring_ptr >= SCALE_SLOTS)
			ring_ptr = 0;
		learned_key[ring_ptr] = pc;
		ring_ptr = (ring_ptr + 1) % SCALE_SLOTS;
		offsets_stale = 1'b1;
	endfunction

	// seed keys with 0, then ascending sweeps spread offsets to their neighbors
	function automatic void refresh_offsets();
		bit filled[PITCH_CLASSES];
		bit gap_seen;
		int sweeps;
		int i;
		int lft;
		int rgt;
		for (i = 0; i < PITCH_CLASSES; i++)
			filled[i] = 1'b0;
		low_key  = LOW_KEY_RST;
		high_key = HIGH_KEY_RST;
		for (i = 0; i < SCALE_SLOTS; i++) begin
			class_offset[learned_key[i]] = 0;
			filled[learned_key[i]] = 1'b1;
			if (learned_key[i] < low_key)
				low_key = learned_key[i];
			if (learned_key[i] > high_key)
				high_key = learned_key[i];
		end
		gap_seen = 1'b1;
		sweeps   = 0;
		while (gap_seen && sweeps < MAX_SWEEPS) begin
			gap_seen = 1'b0;
			sweeps++;
			for (i = 0; i < PITCH_CLASSES; i++) begin
				if (filled[i]) begin
					lft = (i + PITCH_CLASSES - 1) % PITCH_CLASSES;
					rgt = (i + 1) % PITCH_CLASSES;
					if (!filled[lft]) begin
						class_offset[lft] = class_offset[i] + 1;
						filled[lft] = 1'b1;
					end else if (!filled[rgt]) begin
						class_offset[rgt] = class_offset[i] - 1;
						filled[rgt] = 1'b1;
					end
				end else begin
					gap_seen = 1'b1;
				end
			end
		end
		offsets_stale = 1'b0;
	endfunction

	function automatic logic [OUT_W-1:0] predict_pitch(logic [NOTE_W-1:0] n,
			logic signed [SHIFT_W-1:0] s);
		int v;
		int ceiling;
		if (offsets_stale)
			refresh_offsets();
		v = int'(n) + int'(s);
		ceiling = TOP_OFFSET + int'(high_key);
		if (v < int'(low_key))
			v = int'(low_key);
		else if (v > ceiling)
			v = ceiling;
		if (v < 0)
			v = 0;
		return OUT_W'(v + class_offset[v % PITCH_CLASSES]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [OUT_W-1:0] want;
		if (!arst_n) begin
			clear_scale();
			pitch_expect.delete();
		end else begin
			// result side first: a new transfer at this edge cannot be answered yet
			if (done === 1'b1) begin
				if (pitch_expect.size() == 0) begin
					faults++;
					if (faults <= REPORT_MAX)
						$display("%0t: result %0d with nothing outstanding",
							$time, quantized_note);
				end else begin
					want = pitch_expect.pop_front();
					if (quantized_note !== want) begin
						faults++;
						if (faults <= REPORT_MAX)
							$display("%0t: quantized_note expected %0d got %0d",
								$time, want, quantized_note);
					end
				end
			end
			if (start && !busy) begin
				if (mode == MODE_RECORD)
					learn_class(note);
				else
					pitch_expect.push_back(predict_pitch(note, shift));
			end
		end
		fault_count <= faults;
		notes_owed  <= pitch_expect.size();
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for learned_scale_pitch_quantizer
// Drives directed and random record and quantize transfers, with and without random sender gaps; the checker
// beside the block predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import lspq_pkg::*;

	// worst transfer is a quantize with a full 14-sweep rebuild plus a sender
	// gap; ~1850 of those, taken several times over
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int TAIL_CYCLES = 200;   // covers a full rebuild after the last transfer
	localparam int PHASE_ITEMS = 600;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic                      mode;
	logic [NOTE_W-1:0]         note;
	logic signed [SHIFT_W-1:0] shift;
	logic                      done;
	logic [OUT_W-1:0]          quantized_note;

	int fault_count;
	int notes_owed;
	int cycle_count = 0;
	int gap_pct;        // chance in percent that the sender idles a cycle

	learned_scale_pitch_quantizer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.note          (note),
		.shift         (shift),
		.done          (done),
		.quantized_note(quantized_note)
	);

	lspq_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.note          (note),
		.shift         (shift),
		.done          (done),
		.quantized_note(quantized_note),
		.fault_count   (fault_count),
		.notes_owed    (notes_owed)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Present one transfer and hold it until it is taken. Called right after a
	// rising edge; start is left high so back-to-back transfers never drop it.
	task automatic send_note(logic m, logic [NOTE_W-1:0] n, logic signed [SHIFT_W-1:0] s);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		mode  <= m;
		note  <= n;
		shift <= s;
		do
			@(posedge clk);
		while (busy);
	endtask

	// drop start and wait until every quantize has been answered
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (notes_owed != 0)
			@(posedge clk);
	endtask

	task automatic send_random();
		logic                      m;
		logic signed [SHIFT_W-1:0] s;
		// lean toward quantize so rebuilt maps get exercised, but keep the
		// scale churning with plenty of records
		m = ($urandom_range(99) < 40) ? MODE_RECORD : MODE_QUANTIZE;
		if ($urandom_range(1))
			s = SHIFT_W'($urandom_range(255));
		else
			s = SHIFT_W'(int'($urandom_range(48)) - 24);
		send_note(m, NOTE_W'($urandom_range(127)), s);
	endtask

	initial begin
		int i;
		start   <= 1'b0;
		mode    <= MODE_RECORD;
		note    <= '0;
		shift   <= '0;
		gap_pct = 38;
		arst_n  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n  <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// quantize on the reset map: clamp window is [11,108]
		send_note(MODE_QUANTIZE, 7'd0,   -8'sd128);
		send_note(MODE_QUANTIZE, 7'd127, 8'sd127);
		send_note(MODE_QUANTIZE, 7'd60,  8'sd0);
		// reset slots already hold class 0, so these change nothing
		send_note(MODE_RECORD,   7'd0,   8'sd0);
		send_note(MODE_RECORD,   7'd120, -8'sd1);
		send_note(MODE_QUANTIZE, 7'd5,   8'sd3);
		// first real change, then a quantize that triggers the rebuild
		send_note(MODE_RECORD,   7'd127, -8'sd1);
		send_note(MODE_QUANTIZE, 7'd64,  8'sd0);
		// fill the ring and wrap it so class 0 drops out of the scale
		send_note(MODE_RECORD,   7'd61,  8'sd0);
		send_note(MODE_RECORD,   7'd66,  8'sd0);
		send_note(MODE_RECORD,   7'd70,  8'sd0);
		send_note(MODE_RECORD,   7'd75,  8'sd0);
		send_note(MODE_RECORD,   7'd74,  8'sd0);
		send_note(MODE_RECORD,   7'd11,  8'sd0);
		send_note(MODE_QUANTIZE, 7'd0,   8'sd0);
		send_note(MODE_QUANTIZE, 7'd127, 8'sd127);
		send_note(MODE_QUANTIZE, 7'd100, -8'sd100);
		send_note(MODE_QUANTIZE, 7'd42,  8'sh55);
		send_note(MODE_QUANTIZE, 7'd85,  8'shAA);
		send_note(MODE_QUANTIZE, 7'd127, -8'sd1);
		// replace class 1 in the scale with class 9 and quantize again
		send_note(MODE_RECORD,   7'd9,   8'sd0);
		send_note(MODE_QUANTIZE, 7'd1,   8'sd0);

		// --- random, sender gaps 38% ---
		for (i = 0; i < PHASE_ITEMS; i++)
			send_random();
		// sender holds off until everything is back
		drain_results();

		// --- random, sender gaps 63% ---
		gap_pct = 63;
		for (i = 0; i < PHASE_ITEMS; i++)
			send_random();

		// --- random, back-to-back ---
		gap_pct = 0;
		for (i = 0; i < PHASE_ITEMS; i++)
			send_random();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fault_count == 0 && notes_owed == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
